@@ rtl/multi_sensor_distance_smoother_assert.svh @@
// assertion helpers for the distance smoother, clocked on clock, disabled in reset
`ifndef MULTI_SENSOR_DISTANCE_SMOOTHER_ASSERT_SVH
`define MULTI_SENSOR_DISTANCE_SMOOTHER_ASSERT_SVH

// same-cycle implication
`define MSDS_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("distance smoother assertion failed");

// next-cycle implication
`define MSDS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("distance smoother assertion failed");

`endif

@@ rtl/msds_pkg.sv @@
package msds_pkg;

   localparam int RAW_W       = 16;
   localparam int SENSOR_W    = 2;
   localparam int DIST_W      = 9;
   localparam int CSR_INDEX_W = 2;

   localparam int MAX_VALID    = 400;
   localparam int NONE_NEAREST = 401;
   localparam int START_VALUE  = 2;
   localparam int RED_RESET    = 5;
   localparam int YELLOW_RESET = 10;

   typedef logic [DIST_W-1:0] dist_type;

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_RED_LIMIT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_YELLOW_LIMIT = 2'd1;

   typedef enum logic [1:0] {
      ZONE_NONE   = 2'd0,
      ZONE_RED    = 2'd1,
      ZONE_YELLOW = 2'd2,
      ZONE_GREEN  = 2'd3
   } zone_type;

endpackage

@@ rtl/msds_ram.sv @@
module msds_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/multi_sensor_distance_smoother.sv @@
// an accepted request is registered in stage one, then in the output register
// one request per cycle unless stalled; the ring memory's registered read sets two stages
// a stalled response holds in the output register while one more request waits in stage one
// reset (synchronous, active high) restores limits, ring positions, held values and totals
// ring entries are not cleared: a per-sensor wrap flag reads unwritten entries as 2
`include "multi_sensor_distance_smoother_assert.svh"

module multi_sensor_distance_smoother #(
   parameter int SENSOR_COUNT = 4,
   parameter int WINDOW_DEPTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [msds_pkg::RAW_W-1:0]        req_raw_distance,
   input  logic [msds_pkg::SENSOR_W-1:0]     req_sensor_number,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [msds_pkg::DIST_W-1:0]       rsp_smoothed_distance,
   output logic [msds_pkg::DIST_W-1:0]       rsp_nearest_distance,
   output msds_pkg::zone_type                rsp_zone,
   // configuration
   input  logic                              csr_write_enable,
   input  logic [msds_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [msds_pkg::DIST_W-1:0]       csr_write_data
);

   import msds_pkg::*;

   localparam int SIDX_W    = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
   localparam int POS_W     = $clog2(WINDOW_DEPTH);
   localparam int SLOTS     = SENSOR_COUNT * WINDOW_DEPTH;
   localparam int ADDR_W    = $clog2(SLOTS);
   localparam int TOT_W     = $clog2(MAX_VALID * WINDOW_DEPTH + 1);
   // total / WINDOW_DEPTH as a multiply by a rounded-up reciprocal, exact for every total
   localparam int DIV_SHIFT = TOT_W + POS_W;
   localparam int MULT_W    = TOT_W + 1;
   localparam int DIV_MULT  = ((1 << DIV_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
   localparam int PROD_W    = TOT_W + MULT_W;
   localparam int POS_LAST  = WINDOW_DEPTH - 1;

   // what stage one needs to finish a request
   typedef struct packed {
      logic              in_range;   // sensor number addresses a real sensor
      logic [SIDX_W-1:0] sidx;
      logic [ADDR_W-1:0] addr;       // ring slot being replaced
      logic              fresh;      // slot never written since reset
      logic              take;       // reading replaces the held value
      dist_type          raw;
   } stage_type;

   // configuration registers
   dist_type red_limit_ff, yellow_limit_ff;

   // per-sensor state
   logic [POS_W-1:0] wpos_ff    [SENSOR_COUNT];
   logic             wrapped_ff [SENSOR_COUNT];
   dist_type         held_ff    [SENSOR_COUNT];
   logic [TOT_W-1:0] total_ff   [SENSOR_COUNT];
   dist_type         latest_ff  [SENSOR_COUNT];

   // pipeline
   logic      s1_valid_ff;
   stage_type s1_ff, s1_in;
   logic      rsp_valid_ff;
   dist_type  rsp_smooth_ff, rsp_nearest_ff;
   zone_type  rsp_zone_ff;

   // stage zero signals
   logic              accept;
   logic              req_in_range;
   logic [SIDX_W-1:0] req_sidx;
   logic [POS_W-1:0]  req_pos;
   logic              raw_take;

   // stage one signals
   logic             commit;
   dist_type         ram_rd_data;
   dist_type         old_value;
   dist_type         held_in;
   logic [TOT_W-1:0] total_in;
   logic [PROD_W-1:0] product;
   dist_type         smooth_in;
   dist_type         nearest_in;
   zone_type         zone_in;

   // handshake: stage one drains whenever the output register is free or being taken
   assign commit    = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------------------------------
   // stage zero: pick the ring slot, launch the memory read, advance the write position
   // ---------------------------------------------------------------------------------------
   assign req_in_range = (int'(req_sensor_number) < SENSOR_COUNT);
   assign req_sidx     = SIDX_W'(req_sensor_number);
   assign req_pos      = wpos_ff[req_sidx];
   // zero means no object; one and anything above the range are ignored
   assign raw_take     = (req_raw_distance == '0) ||
                         ((req_raw_distance >= RAW_W'(START_VALUE)) &&
                          (req_raw_distance <= RAW_W'(MAX_VALID)));

   always_comb begin
      s1_in.in_range = req_in_range;
      s1_in.sidx     = req_sidx;
      s1_in.addr     = ADDR_W'(req_sidx) * ADDR_W'(WINDOW_DEPTH) + ADDR_W'(req_pos);
      s1_in.fresh    = !wrapped_ff[req_sidx];
      s1_in.take     = raw_take;
      s1_in.raw      = DIST_W'(req_raw_distance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (commit) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
   end

   // ring positions move at accept so back-to-back requests for one sensor see the next slot
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            wpos_ff[i]    <= '0;
            wrapped_ff[i] <= 1'b0;
         end
      end else if (accept && req_in_range) begin
         if (req_pos == POS_W'(POS_LAST)) begin
            wpos_ff[req_sidx]    <= '0;
            wrapped_ff[req_sidx] <= 1'b1;
         end else begin
            wpos_ff[req_sidx] <= req_pos + POS_W'(1);
         end
      end
   end

   // ring storage: one read at accept, one write at commit
   msds_ram #(
      .WIDTH (DIST_W),
      .DEPTH (SLOTS)
   ) u_ring (
      .clock   (clock),
      .wr_en   (commit && s1_ff.in_range),
      .wr_addr (s1_ff.addr),
      .wr_data (held_in),
      .rd_en   (accept),
      .rd_addr (s1_in.addr),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------------------------------
   // stage one: running total, window mean, nearest over all sensors, zone
   // ---------------------------------------------------------------------------------------
   assign old_value = s1_ff.fresh ? DIST_W'(START_VALUE) : ram_rd_data;
   assign held_in   = s1_ff.take ? s1_ff.raw : held_ff[s1_ff.sidx];
   assign total_in  = total_ff[s1_ff.sidx] - TOT_W'(old_value) + TOT_W'(held_in);
   assign product   = PROD_W'(total_in) * PROD_W'(DIV_MULT);

   always_comb begin
      smooth_in = s1_ff.in_range ? DIST_W'(product >> DIV_SHIFT) : '0;
   end

   // smallest nonzero latest mean, with this request's sensor taking its new mean
   always_comb begin
      dist_type cand;
      nearest_in = DIST_W'(NONE_NEAREST);
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         cand = (s1_ff.in_range && (s1_ff.sidx == SIDX_W'(i))) ? smooth_in : latest_ff[i];
         if ((cand != '0) && (cand < nearest_in)) begin
            nearest_in = cand;
         end
      end
   end

   // red wins when the limits overlap
   always_comb begin
      priority if (nearest_in <= red_limit_ff) begin
         zone_in = ZONE_RED;
      end else if (nearest_in <= yellow_limit_ff) begin
         zone_in = ZONE_YELLOW;
      end else if (nearest_in <= DIST_W'(MAX_VALID)) begin
         zone_in = ZONE_GREEN;
      end else begin
         zone_in = ZONE_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            held_ff[i]   <= DIST_W'(START_VALUE);
            total_ff[i]  <= TOT_W'(START_VALUE * WINDOW_DEPTH);
            latest_ff[i] <= DIST_W'(START_VALUE);
         end
      end else if (commit && s1_ff.in_range) begin
         held_ff[s1_ff.sidx]   <= held_in;
         total_ff[s1_ff.sidx]  <= total_in;
         latest_ff[s1_ff.sidx] <= smooth_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_smooth_ff  <= smooth_in;
         rsp_nearest_ff <= nearest_in;
         rsp_zone_ff    <= zone_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_smoothed_distance = rsp_smooth_ff;
   assign rsp_nearest_distance  = rsp_nearest_ff;
   assign rsp_zone              = rsp_zone_ff;

   // ---------------------------------------------------------------------------------------
   // configuration writes; unknown indexes are dropped
   // ---------------------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         red_limit_ff    <= DIST_W'(RED_RESET);
         yellow_limit_ff <= DIST_W'(YELLOW_RESET);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_RED_LIMIT: begin
               red_limit_ff <= csr_write_data;
            end
            CSR_YELLOW_LIMIT: begin
               yellow_limit_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------------------
   `MSDS_ASSERT_IMPL(a_nearest_nonzero, rsp_valid, rsp_nearest_distance != '0)
   `MSDS_ASSERT_IMPL(a_zone_none_far, rsp_valid && (rsp_zone == ZONE_NONE),
                     rsp_nearest_distance == DIST_W'(NONE_NEAREST))
   `MSDS_ASSERT_IMPL(a_smooth_in_range, rsp_valid, rsp_smoothed_distance <= DIST_W'(MAX_VALID))
   `MSDS_ASSERT_NEXT(a_accept_fills_stage, req_valid && req_ready, s1_valid_ff)
   `MSDS_ASSERT_IMPL(a_stall_blocks_request, s1_valid_ff && rsp_valid && !rsp_ready, !req_ready)

endmodule

@@ sim/multi_sensor_distance_smoother_test.sv @@
module multi_sensor_distance_smoother_test;
   import msds_pkg::*;

   localparam int SENSORS     = 4;
   localparam int DEPTH       = 8;
   localparam int CYCLE_LIMIT = 200000;

   // indexes past the two limit registers, writes there must be dropped
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HIGH = 2'd3;

   typedef struct packed {
      dist_type smoothed;
      dist_type nearest;
      zone_type zone;
   } reading_result_type;

   typedef struct packed {
      logic [RAW_W-1:0]    raw;
      logic [SENSOR_W-1:0] sensor;
      logic                typed;
      reading_result_type  want;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [RAW_W-1:0]       req_raw_distance = '0;
   logic [SENSOR_W-1:0]    req_sensor_number = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   dist_type               rsp_smoothed_distance;
   dist_type               rsp_nearest_distance;
   zone_type               rsp_zone;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   dist_type               csr_write_data = '0;

   // predictor state: per-sensor ring of held readings with a running total
   dist_type    ring_store [SENSORS][DEPTH];
   logic [2:0]  ring_slot [SENSORS];
   dist_type    held_reading [SENSORS];
   logic [11:0] ring_total [SENSORS];
   dist_type    last_mean [SENSORS];
   dist_type    red_limit_q;
   dist_type    yellow_limit_q;

   reading_result_type expected_readings [$];
   int                 error_count = 0;
   int                 cycle_count = 0;
   int                 burst_left  = 0;

   // first rows are fresh after reset, so every window still averages 2
   stim_row_type directed_rows [25] = '{
      '{16'd1,     2'd0, 1'b1, '{9'd2, 9'd2, ZONE_RED}},    // one cm is ignored
      '{16'd65535, 2'd1, 1'b1, '{9'd2, 9'd2, ZONE_RED}},    // top of the raw range
      '{16'd401,   2'd2, 1'b1, '{9'd2, 9'd2, ZONE_RED}},    // just past the valid range
      '{16'd2,     2'd3, 1'b1, '{9'd2, 9'd2, ZONE_RED}},    // smallest valid reading
      '{16'd400,   2'd0, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd400,   2'd0, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd0,     2'd1, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},   // no object
      '{16'd399,   2'd2, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd3,     2'd3, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd1,     2'd0, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},   // repeats a held 400
      '{16'd65535, 2'd1, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},   // repeats a held 0
      '{16'h8000,  2'd2, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'h7fff,  2'd3, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd256,   2'd0, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd255,   2'd1, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd10,    2'd2, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd11,    2'd3, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd5,     2'd0, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd6,     2'd1, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd400,   2'd2, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd400,   2'd3, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd400,   2'd0, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd400,   2'd1, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd400,   2'd2, 1'b0, '{9'd0, 9'd0, ZONE_NONE}},
      '{16'd400,   2'd3, 1'b0, '{9'd0, 9'd0, ZONE_NONE}}
   };

   multi_sensor_distance_smoother dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_raw_distance      (req_raw_distance),
      .req_sensor_number     (req_sensor_number),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_smoothed_distance (rsp_smoothed_distance),
      .rsp_nearest_distance  (rsp_nearest_distance),
      .rsp_zone              (rsp_zone),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always #6 clock = ~clock;

   // watchdog, also the time base for the receiver's stall pattern
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // receiver: rotates through always-ready, coin-flip, one-in-four and mostly-ready
   always @(posedge clock) begin
      case ((cycle_count / 97) % 4)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_ready <= (cycle_count % 4 == 0);
         end
         default: begin
            rsp_ready <= ($urandom_range(0, 4) != 0);
         end
      endcase
   end

   // response check, sampled mid-cycle so values are the ones seen at the next edge
   always @(negedge clock) begin
      reading_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_smoothed_distance !== want.smoothed) begin
               $error("smoothed_distance expected %0d actual %0d",
                      want.smoothed, rsp_smoothed_distance);
               error_count++;
            end
            if (rsp_nearest_distance !== want.nearest) begin
               $error("nearest_distance expected %0d actual %0d",
                      want.nearest, rsp_nearest_distance);
               error_count++;
            end
            if (rsp_zone !== want.zone) begin
               $error("zone expected %0d actual %0d", want.zone, rsp_zone);
               error_count++;
            end
         end
      end
   end

   task automatic clear_filter_model();
      for (int s = 0; s < SENSORS; s++) begin
         for (int d = 0; d < DEPTH; d++) ring_store[s][d] = DIST_W'(START_VALUE);
         ring_slot[s]    = '0;
         held_reading[s] = DIST_W'(START_VALUE);
         ring_total[s]   = 12'(START_VALUE * DEPTH);
         last_mean[s]    = DIST_W'(START_VALUE);
      end
      red_limit_q    = DIST_W'(RED_RESET);
      yellow_limit_q = DIST_W'(YELLOW_RESET);
   endtask

   // one reading through the filter: update the ring, then rescan every sensor's mean
   function automatic reading_result_type apply_reading(input logic [RAW_W-1:0] raw,
                                                        input logic [SENSOR_W-1:0] sensor);
      logic [2:0]         slot;
      dist_type           mean;
      dist_type           best;
      reading_result_type r;
      mean = '0;
      if (sensor < SENSORS) begin
         // out-of-range raw values leave the held reading alone
         if (raw == 0 || (raw >= START_VALUE && raw <= MAX_VALID))
            held_reading[sensor] = raw[DIST_W-1:0];
         slot = ring_slot[sensor];
         ring_total[sensor] = ring_total[sensor] - ring_store[sensor][slot]
                              + held_reading[sensor];
         ring_store[sensor][slot] = held_reading[sensor];
         ring_slot[sensor] = slot + 3'd1;
         mean = DIST_W'(ring_total[sensor] / DEPTH);
         last_mean[sensor] = mean;
      end
      best = DIST_W'(NONE_NEAREST);
      for (int s = 0; s < SENSORS; s++)
         if (last_mean[s] != 0 && last_mean[s] < best) best = last_mean[s];
      r.smoothed = mean;
      r.nearest  = best;
      // red wins when the limits overlap
      if (best <= red_limit_q)         r.zone = ZONE_RED;
      else if (best <= yellow_limit_q) r.zone = ZONE_YELLOW;
      else if (best <= MAX_VALID)      r.zone = ZONE_GREEN;
      else                             r.zone = ZONE_NONE;
      return r;
   endfunction

   // sender: bursts of random length, random gaps between them
   task automatic send_reading(input logic [RAW_W-1:0] raw, input logic [SENSOR_W-1:0] sensor,
                               input logic typed = 1'b0,
                               input reading_result_type typed_want = '0);
      int                 gap;
      logic               hit;
      reading_result_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_raw_distance  <= raw;
      req_sensor_number <= sensor;
      do begin
         @(negedge clock);
         hit = req_ready;
         if (hit) begin
            predicted = apply_reading(raw, sensor);
            expected_readings.push_back(typed ? typed_want : predicted);
         end
         @(posedge clock);
      end while (!hit);
   endtask

   // drop valid and wait out every outstanding response before touching the limits
   task automatic drain_requests();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one write, then a pause with the enable low so back-to-back writes never pile onto one edge
   task automatic write_limit(input logic [CSR_INDEX_W-1:0] index, input dist_type value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_RED_LIMIT)         red_limit_q    = value;
      else if (index == CSR_YELLOW_LIMIT) yellow_limit_q = value;
      @(posedge clock);
   endtask

   function automatic logic [RAW_W-1:0] pick_raw();
      case ($urandom_range(0, 6))
         0:       return 16'd0;
         1:       return RAW_W'(MAX_VALID);
         2:       return RAW_W'($urandom_range(START_VALUE, MAX_VALID));
         3:       return RAW_W'($urandom_range(START_VALUE, 30));
         4:       return 16'd1;
         5:       return RAW_W'($urandom_range(MAX_VALID + 1, 65535));
         default: return RAW_W'($urandom_range(0, 65535));
      endcase
   endfunction

   // one random request pattern; returns how many requests it sent
   task automatic random_sequence(input int kind, output int sent);
      logic [RAW_W-1:0]    raw;
      logic [SENSOR_W-1:0] sensor;
      int                  runs;
      sent = 0;
      case (kind)
         0: begin
            // lone request, fully random
            send_reading(RAW_W'($urandom_range(0, 65535)),
                         SENSOR_W'($urandom_range(0, SENSORS - 1)));
            sent = 1;
         end
         1, 2, 3, 4: begin
            // steady run on one sensor repeats one value into its window
            sensor = SENSOR_W'($urandom_range(0, SENSORS - 1));
            raw    = pick_raw();
            runs   = $urandom_range(4, 10);
            repeat (runs) send_reading(raw, sensor);
            sent = runs;
         end
         5, 6: begin
            // small distances around the zone limits
            repeat (6) send_reading(RAW_W'($urandom_range(0, 30)),
                                    SENSOR_W'($urandom_range(0, SENSORS - 1)));
            sent = 6;
         end
         7: begin
            // ignored readings only, the held value keeps refilling the ring
            sensor = SENSOR_W'($urandom_range(0, SENSORS - 1));
            repeat (5) begin
               raw = ($urandom_range(0, 2) == 0) ? 16'd1
                                                 : RAW_W'($urandom_range(MAX_VALID + 1, 65535));
               send_reading(raw, sensor);
            end
            sent = 5;
         end
         8: begin
            // no object on any sensor: every mean drops to zero, nearest goes to 401
            for (int round = 0; round < DEPTH; round++)
               for (int s = 0; s < SENSORS; s++) send_reading(16'd0, SENSOR_W'(s));
            sent = DEPTH * SENSORS;
         end
         default: begin
            // every sensor sees the same distance, so nearest lands on it
            raw = RAW_W'(($urandom_range(0, 1) == 0) ? $urandom_range(START_VALUE, 30)
                                                     : $urandom_range(START_VALUE, MAX_VALID));
            for (int round = 0; round < DEPTH; round++)
               for (int s = 0; s < SENSORS; s++) send_reading(raw, SENSOR_W'(s));
            sent = DEPTH * SENSORS;
         end
      endcase
   endtask

   // limit pairs per phase: both extremes, a wide split, an overlap where red wins, 255 under 400
   dist_type phase_red    [5] = '{9'd0, 9'd400, 9'd20, 9'd300, 9'd255};
   dist_type phase_yellow [5] = '{9'd0, 9'd400, 9'd200, 9'd100, 9'd400};

   initial begin
      int sent;
      int phase_items;
      clear_filter_model();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed walk at the reset limits
      foreach (directed_rows[i])
         send_reading(directed_rows[i].raw, directed_rows[i].sensor,
                      directed_rows[i].typed, directed_rows[i].want);

      for (int phase = 0; phase < 5; phase++) begin
         drain_requests();
         write_limit(CSR_RED_LIMIT, phase_red[phase]);
         write_limit(CSR_YELLOW_LIMIT, phase_yellow[phase]);
         // spare indexes carry junk that must not land anywhere
         write_limit(CSR_SPARE_LOW, DIST_W'($urandom_range(0, 511)));
         write_limit(CSR_SPARE_HIGH, DIST_W'($urandom_range(0, 511)));
         // each phase opens with an all-clear so the empty zone shows up
         random_sequence(8, sent);
         phase_items = sent;
         while (phase_items < 75) begin
            random_sequence($urandom_range(0, 9), sent);
            phase_items += sent;
         end
      end

      drain_requests();
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/msds_pkg.sv
rtl/msds_ram.sv
rtl/multi_sensor_distance_smoother.sv
sim/multi_sensor_distance_smoother_test.sv
